>>> sv/mrkx_pkg.sv
// shared types and constants for the multi-round rolling key xor block
// no dependencies; used by every module of the block by scoped names

package mrkx_pkg;

	localparam int KEY_LENGTH_DEF = 32;
	localparam int KEY_LENGTH_MAX = 64;
	localparam int KEY_REGS       = 4;
	localparam int KEY_BYTES      = 32;
	localparam int KEY_IDX_W      = 7;
	localparam int APB_ADDR_W     = 5;
	localparam int APB_DATA_W     = 64;
	localparam int ROUND_BONUS    = 1000;
	localparam int STEP_PERIOD    = 10;
	localparam int ACC_W          = 17;
	localparam int PROD_W         = 25;
	localparam int COUNT_W        = 18;
	localparam int STEP_W         = 9;
	localparam int MOD_W          = 16;

	localparam logic [7:0]            SKIP_CHAR = 8'h30;
	localparam logic [APB_DATA_W-1:0] KEY_RESET = 64'h3030303030303030;
	localparam logic [COUNT_W-1:0]    COUNT_RESET = 18'd1001;

	localparam logic [1:0] REG_KEY_0 = 2'd0;
	localparam logic [1:0] REG_KEY_1 = 2'd1;
	localparam logic [1:0] REG_KEY_2 = 2'd2;
	localparam logic [1:0] REG_KEY_3 = 2'd3;

	typedef enum logic [2:0] {
		GEN_START,
		GEN_SCAN,
		GEN_ADD,
		GEN_PAD_INIT,
		GEN_PAD_STEP,
		GEN_DONE
	} gen_state_t;

	typedef enum logic {
		XS_IDLE,
		XS_READ
	} xfer_state_t;

	typedef struct packed {
		logic ready;
		logic wr_en;
	} gen_status_t;

endpackage

>>> sv/mrkx_cfg.sv
// apb register file holding the four 64-bit key words and the key byte lookup
// depends on mrkx_pkg

module mrkx_cfg #(
	parameter int KEY_LENGTH = mrkx_pkg::KEY_LENGTH_DEF,
	parameter int IDX_W      = $clog2(KEY_LENGTH + 2)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [mrkx_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [mrkx_pkg::APB_DATA_W-1:0] pwdata,
	output logic [mrkx_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready,
	output logic                            key_wr,
	input  logic [IDX_W-1:0]                key_addr,
	output logic [7:0]                      key_byte
);

	logic [mrkx_pkg::APB_DATA_W-1:0] key_q [mrkx_pkg::KEY_REGS];
	logic [1:0]                      reg_idx;
	logic [mrkx_pkg::KEY_IDX_W-1:0]  addr_ext;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:3];
	assign key_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < mrkx_pkg::KEY_REGS; i++) begin
				key_q[i] <= mrkx_pkg::KEY_RESET;
			end
		end else if (key_wr) begin
			key_q[reg_idx] <= pwdata;
		end
	end

	always_comb begin
		case (reg_idx)
			mrkx_pkg::REG_KEY_0: prdata = key_q[0];
			mrkx_pkg::REG_KEY_1: prdata = key_q[1];
			mrkx_pkg::REG_KEY_2: prdata = key_q[2];
			mrkx_pkg::REG_KEY_3: prdata = key_q[3];
			default:             prdata = '0;
		endcase
	end

	// bytes past the key length or past the registers read as zero
	always_comb begin
		addr_ext = mrkx_pkg::KEY_IDX_W'(key_addr);
		if (addr_ext < mrkx_pkg::KEY_IDX_W'(KEY_LENGTH) &&
				addr_ext < mrkx_pkg::KEY_IDX_W'(mrkx_pkg::KEY_BYTES)) begin
			key_byte = key_q[addr_ext[4:3]][{addr_ext[2:0], 3'b000} +: 8];
		end else begin
			key_byte = '0;
		end
	end

endmodule

>>> sv/mrkx_pad_gen.sv
// sequencer that derives the round count and then builds the pad byte by byte
// depends on mrkx_pkg; reads key bytes from mrkx_cfg, writes the pad memory in the top level

module mrkx_pad_gen #(
	parameter int KEY_LENGTH = mrkx_pkg::KEY_LENGTH_DEF,
	parameter int IDX_W      = $clog2(KEY_LENGTH + 2),
	parameter int ADDR_W     = $clog2(KEY_LENGTH)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  restart,
	output logic [IDX_W-1:0]      key_addr,
	input  logic [7:0]            key_byte,
	output mrkx_pkg::gen_status_t status,
	output logic [ADDR_W-1:0]     wr_addr,
	output logic [7:0]            wr_data
);

	mrkx_pkg::gen_state_t state_q, state_d;

	logic        [IDX_W-1:0]                 idx_q;
	logic signed [mrkx_pkg::ACC_W-1:0]       acc_q;
	logic signed [mrkx_pkg::PROD_W-1:0]      prod_q;
	logic signed [mrkx_pkg::COUNT_W-1:0]     count_q;
	logic        [ADDR_W-1:0]                p_q;
	logic        [3:0]                       d_q;
	logic        [7:0]                       term_q;
	logic        [7:0]                       xacc_q;
	logic        [mrkx_pkg::STEP_W-1:0]      steps_q;

	logic signed [7:0]                       kb_s;
	logic signed [mrkx_pkg::PROD_W-1:0]      prod_d;
	logic signed [mrkx_pkg::PROD_W-1:0]      sum;
	logic        [mrkx_pkg::PROD_W-1:0]      mag;
	logic signed [mrkx_pkg::ACC_W-1:0]       mod_res;
	logic                                    scan_end;
	logic                                    count_pos;
	logic                                    last_p;

	assign kb_s      = $signed(key_byte);
	assign prod_d    = acc_q * kb_s;
	assign sum       = prod_q + mrkx_pkg::PROD_W'(kb_s);
	assign mag       = sum[mrkx_pkg::PROD_W-1] ? mrkx_pkg::PROD_W'(-sum) : sum;
	assign scan_end  = idx_q >= IDX_W'(KEY_LENGTH);
	assign count_pos = !count_q[mrkx_pkg::COUNT_W-1] && (count_q != '0);
	assign last_p    = p_q == ADDR_W'(KEY_LENGTH - 1);
	assign wr_addr   = p_q;
	assign wr_data   = xacc_q;

	// remainder truncated toward zero, as the sign of the dividend
	always_comb begin
		if (sum[mrkx_pkg::PROD_W-1]) begin
			mod_res = -$signed({1'b0, mag[mrkx_pkg::MOD_W-1:0]});
		end else begin
			mod_res = $signed({1'b0, mag[mrkx_pkg::MOD_W-1:0]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mrkx_pkg::GEN_START;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		key_addr     = idx_q;
		status.ready = 1'b0;
		status.wr_en = 1'b0;
		case (state_q)
			mrkx_pkg::GEN_START: begin
				state_d = mrkx_pkg::GEN_SCAN;
			end
			mrkx_pkg::GEN_SCAN: begin
				if (scan_end) begin
					state_d = mrkx_pkg::GEN_PAD_INIT;
				end else if (key_byte != mrkx_pkg::SKIP_CHAR) begin
					state_d = mrkx_pkg::GEN_ADD;
				end
			end
			mrkx_pkg::GEN_ADD: begin
				key_addr = idx_q + IDX_W'(1);
				state_d  = mrkx_pkg::GEN_SCAN;
			end
			mrkx_pkg::GEN_PAD_INIT: begin
				key_addr = IDX_W'(p_q);
				state_d  = mrkx_pkg::GEN_PAD_STEP;
			end
			mrkx_pkg::GEN_PAD_STEP: begin
				if (steps_q == '0) begin
					status.wr_en = 1'b1;
					state_d = last_p ? mrkx_pkg::GEN_DONE : mrkx_pkg::GEN_PAD_INIT;
				end
			end
			mrkx_pkg::GEN_DONE: begin
				status.ready = 1'b1;
			end
			default: begin
				state_d = mrkx_pkg::GEN_START;
			end
		endcase
		if (restart) begin
			state_d = mrkx_pkg::GEN_START;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			acc_q   <= mrkx_pkg::ACC_W'(1);
			count_q <= mrkx_pkg::COUNT_RESET;
			p_q     <= '0;
			d_q     <= '0;
			steps_q <= '0;
		end else begin
			case (state_q)
				mrkx_pkg::GEN_START: begin
					idx_q <= '0;
					acc_q <= mrkx_pkg::ACC_W'(1);
				end
				mrkx_pkg::GEN_SCAN: begin
					if (scan_end) begin
						count_q <= $signed({acc_q[mrkx_pkg::ACC_W-1], acc_q}) +
							mrkx_pkg::COUNT_W'(mrkx_pkg::ROUND_BONUS);
						p_q     <= '0;
						d_q     <= '0;
					end else if (key_byte == mrkx_pkg::SKIP_CHAR) begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				mrkx_pkg::GEN_ADD: begin
					acc_q <= (mod_res == '0) ? mrkx_pkg::ACC_W'(1) : mod_res;
					idx_q <= idx_q + IDX_W'(2);
				end
				mrkx_pkg::GEN_PAD_INIT: begin
					// terms repeat every 256 rounds, so only count bits 8..0 matter
					steps_q <= count_pos ? count_q[mrkx_pkg::STEP_W-1:0] : '0;
				end
				mrkx_pkg::GEN_PAD_STEP: begin
					if (steps_q == '0) begin
						p_q <= p_q + ADDR_W'(1);
						d_q <= (d_q == 4'(mrkx_pkg::STEP_PERIOD - 1)) ? 4'd0 : d_q + 4'd1;
					end else begin
						steps_q <= steps_q - mrkx_pkg::STEP_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// payload registers of the round count product and of the pad term and xor accumulator
	always_ff @(posedge clk) begin
		case (state_q)
			mrkx_pkg::GEN_SCAN: begin
				prod_q <= prod_d;
			end
			mrkx_pkg::GEN_PAD_INIT: begin
				term_q <= key_byte;
				xacc_q <= '0;
			end
			mrkx_pkg::GEN_PAD_STEP: begin
				if (steps_q != '0) begin
					xacc_q <= xacc_q ^ term_q;
					term_q <= term_q + {4'd0, d_q};
				end
			end
			default: begin
			end
		endcase
	end

endmodule

>>> sv/multi_round_rolling_key_xor.sv
// top level of the multi-round rolling key xor stream transform
// depends on mrkx_pkg, mrkx_cfg and mrkx_pad_gen; holds the pad memory and the byte path
//
// use: bytes enter on the s_ channel (s_tdata byte, s_tuser start of message) and
// leave on the m_ channel, each xored with the pad byte at the running position,
// which wraps at KEY_LENGTH and is cleared by the start flag before that byte.
// the key sits in four 64-bit registers on the apb port at byte addresses 0, 8, 16, 24.
// after reset and after every key write the pad generator rebuilds the pad: a scan
// of the key bytes for the round count, then the pad bytes one at a time on one
// 8-bit adder. s_tready stays low until the pad is built.
// each byte then passes the registered pad memory read and the output register: a
// transfer reads the pad memory, the read step then loads the output register and
// raises m_tvalid. s_tready is low in the read step, so a new byte is taken only
// after the previous one has left the read step.
// when the receiver stalls the output register holds its byte and one more byte
// can be taken and read; the block waits in the read step until the output frees.
// reset returns the key to all '0' characters and the position to zero.

module multi_round_rolling_key_xor #(
	parameter int KEY_LENGTH = mrkx_pkg::KEY_LENGTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      s_tdata,   // data_byte
	input  logic [0:0]                      s_tuser,   // start_of_message
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [7:0]                      m_tdata,   // out_byte
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [mrkx_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [mrkx_pkg::APB_DATA_W-1:0] pwdata,
	output logic [mrkx_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready
);

	localparam int IDX_W  = $clog2(KEY_LENGTH + 2);
	localparam int ADDR_W = $clog2(KEY_LENGTH);

	logic                  key_wr;
	logic [IDX_W-1:0]      key_addr;
	logic [7:0]            key_byte;
	mrkx_pkg::gen_status_t gen_status;
	logic [ADDR_W-1:0]     wr_addr;
	logic [7:0]            wr_data;

	mrkx_pkg::xfer_state_t state_q, state_d;

	logic [7:0]        pad_mem [KEY_LENGTH];
	logic [7:0]        pad_rd_q;
	logic [7:0]        data_q;
	logic [ADDR_W-1:0] pos_q;
	logic [ADDR_W-1:0] pos_cur;
	logic              in_xfer;
	logic              out_load;
	logic              m_tvalid_q;
	logic [7:0]        m_tdata_q;

	mrkx_cfg #(
		.KEY_LENGTH(KEY_LENGTH),
		.IDX_W     (IDX_W)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.key_wr  (key_wr),
		.key_addr(key_addr),
		.key_byte(key_byte)
	);

	mrkx_pad_gen #(
		.KEY_LENGTH(KEY_LENGTH),
		.IDX_W     (IDX_W),
		.ADDR_W    (ADDR_W)
	) u_pad_gen (
		.clk     (clk),
		.arst_n  (arst_n),
		.restart (key_wr),
		.key_addr(key_addr),
		.key_byte(key_byte),
		.status  (gen_status),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	assign s_tready = gen_status.ready && (state_q == mrkx_pkg::XS_IDLE);
	assign in_xfer  = s_tvalid && s_tready;
	assign pos_cur  = s_tuser[0] ? '0 : pos_q;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	always_ff @(posedge clk) begin
		if (gen_status.wr_en) begin
			pad_mem[wr_addr] <= wr_data;
		end
		if (in_xfer) begin
			pad_rd_q <= pad_mem[pos_cur];
			data_q   <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mrkx_pkg::XS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		out_load = 1'b0;
		case (state_q)
			mrkx_pkg::XS_IDLE: begin
				if (in_xfer) begin
					state_d = mrkx_pkg::XS_READ;
				end
			end
			mrkx_pkg::XS_READ: begin
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = mrkx_pkg::XS_IDLE;
				end
			end
			default: begin
				state_d = mrkx_pkg::XS_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (in_xfer) begin
				pos_q <= (pos_cur == ADDR_W'(KEY_LENGTH - 1)) ? '0 : pos_cur + ADDR_W'(1);
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= data_q ^ pad_rd_q;
		end
	end

endmodule
